>>> rtl/core/cartridge_bank_mapper_with_scanline_irq_unit_macros.svh
// Assertion macros for the cartridge bank mapper.
// Taken in by the top level only; no other dependencies.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; used by the top level and cbm_regs.
package cbm_pkg;

    localparam int WORK_RAM_BYTES_DEF = 8192;
    localparam int ADDR_W             = 19;
    localparam logic [5:0] BANK16_RST = 6'd32;

    typedef enum logic [2:0] {
        KIND_CPU_RD   = 3'd0,
        KIND_CPU_WR   = 3'd1,
        KIND_PPU_RD   = 3'd2,
        KIND_PPU_WR   = 3'd3,
        KIND_SCANLINE = 3'd4,
        KIND_IRQ_ACK  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_UNMAPPED = 2'd0,
        ST_MAPPED   = 2'd1,
        ST_HANDLED  = 2'd2
    } status_t;

    // Register windows in 0x8000-0xFFFF, selected by addr[14:13]
    localparam logic [1:0] WIN_BANK = 2'd0;
    localparam logic [1:0] WIN_MIRR = 2'd1;
    localparam logic [1:0] WIN_IRQL = 2'd2;
    localparam logic [1:0] WIN_IRQE = 2'd3;

    // Decoded register update for one beat
    typedef struct packed {
        logic       bank_sel_wr;
        logic       bank_data_wr;
        logic       mirror_wr;
        logic       irq_reload_wr;
        logic       irq_cnt_clr;
        logic       irq_disable;
        logic       irq_enable;
        logic       scanline;
        logic       irq_ack;
        logic [7:0] data;
    } reg_cmd_t;

endpackage

>>> rtl/core/cartridge_bank_mapper_with_scanline_irq_unit.sv
// Cartridge bank mapper with scanline IRQ: top level, event decode and result register.
// Depends on cbm_pkg, cbm_regs, cbm_wram and the assertion macro header.
//
// One bus event per beat and one result per beat. An event is decoded and applied
// in the cycle it is accepted and its result is held in the output register; a new
// event is taken every cycle while the result is drained (in_ready drops only while
// a result is stalled). The work RAM read data is registered and feeds read_data.
// bank16_reg is used when the window bases are rebuilt on each bank-data write;
// reset uses BANK16_RST. Mirroring and the IRQ line on a result reflect state after
// that event.
`include "cartridge_bank_mapper_with_scanline_irq_unit_macros.svh"

module cartridge_bank_mapper_with_scanline_irq_unit #(
    parameter int WORK_RAM_BYTES = cbm_pkg::WORK_RAM_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [5:0]                  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  kind,
    input  logic [15:0]                 addr,
    input  logic [7:0]                  write_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [cbm_pkg::ADDR_W-1:0]  rom_offset,
    output logic [7:0]                  read_data,
    output logic                        irq_active,
    output logic                        mirror_horizontal
);

    localparam int AW     = cbm_pkg::ADDR_W;
    localparam int RAM_AW = $clog2(WORK_RAM_BYTES);

    logic              accept;
    cbm_pkg::reg_cmd_t cmd;
    cbm_pkg::status_t  st;
    logic              use_prg;
    logic              use_chr;
    logic              ram_we;
    logic              ram_re;
    logic              in_ram;
    logic [17:0]       ram_rem;
    logic [RAM_AW-1:0] ram_idx;
    logic [AW-1:0]     prg_base;
    logic [AW-1:0]     chr_base;
    logic [AW-1:0]     mapped;
    logic [7:0]        ram_q;
    logic              irq_pending;
    logic              mirror_h;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [AW-1:0]     mapped_reg;
    logic              ram_rd_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign in_ram   = (addr[15:13] == 3'b011);

    always_comb
    begin
        cmd      = '0;
        cmd.data = write_data;
        st       = cbm_pkg::ST_UNMAPPED;
        use_prg  = 1'b0;
        use_chr  = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        case (kind)
            cbm_pkg::KIND_CPU_RD:
            begin
                if (in_ram)
                begin
                    st     = cbm_pkg::ST_HANDLED;
                    ram_re = 1'b1;
                end
                else if (addr[15])
                begin
                    st      = cbm_pkg::ST_MAPPED;
                    use_prg = 1'b1;
                end
            end
            cbm_pkg::KIND_CPU_WR:
            begin
                if (in_ram)
                begin
                    st     = cbm_pkg::ST_HANDLED;
                    ram_we = 1'b1;
                end
                else if (addr[15])
                begin
                    st = cbm_pkg::ST_HANDLED;
                    case (addr[14:13])
                        cbm_pkg::WIN_BANK:
                        begin
                            cmd.bank_data_wr = addr[0];
                            cmd.bank_sel_wr  = !addr[0];
                        end
                        cbm_pkg::WIN_MIRR:
                        begin
                            // odd address is RAM protect, ignored
                            cmd.mirror_wr = !addr[0];
                        end
                        cbm_pkg::WIN_IRQL:
                        begin
                            cmd.irq_cnt_clr   = addr[0];
                            cmd.irq_reload_wr = !addr[0];
                        end
                        cbm_pkg::WIN_IRQE:
                        begin
                            cmd.irq_enable  = addr[0];
                            cmd.irq_disable = !addr[0];
                        end
                        default:
                        begin
                            cmd.bank_sel_wr = 1'b0;
                        end
                    endcase
                end
            end
            cbm_pkg::KIND_PPU_RD:
            begin
                if (addr[15:13] == 3'b000)
                begin
                    st      = cbm_pkg::ST_MAPPED;
                    use_chr = 1'b1;
                end
            end
            cbm_pkg::KIND_SCANLINE:
            begin
                cmd.scanline = 1'b1;
            end
            cbm_pkg::KIND_IRQ_ACK:
            begin
                cmd.irq_ack = 1'b1;
            end
            default:
            begin
                st = cbm_pkg::ST_UNMAPPED;
            end
        endcase
    end

    // RAM index: 8 KB window offset modulo the RAM size (exact for RAMs of 1 KB or more)
    always_comb
    begin
        ram_rem = {5'b0, addr[12:0]};
        for (int k = 2; k >= 0; k--)
        begin
            if (ram_rem >= (18'(WORK_RAM_BYTES) << k))
            begin
                ram_rem = ram_rem - (18'(WORK_RAM_BYTES) << k);
            end
        end
        ram_idx = ram_rem[RAM_AW-1:0];
    end

    cbm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (accept),
        .cmd         (cmd),
        .prg_sel     (addr[14:13]),
        .chr_sel     (addr[12:10]),
        .prg_base    (prg_base),
        .chr_base    (chr_base),
        .irq_pending (irq_pending),
        .mirror_h    (mirror_h)
    );

    cbm_wram #(
        .DEPTH (WORK_RAM_BYTES)
    ) u_wram (
        .clk   (clk),
        .we    (accept && ram_we),
        .re    (accept && ram_re),
        .addr  (ram_idx),
        .wdata (write_data),
        .rdata (ram_q)
    );

    always_comb
    begin
        if (use_prg)
        begin
            mapped = prg_base + {6'b0, addr[12:0]};
        end
        else if (use_chr)
        begin
            mapped = chr_base + {9'b0, addr[9:0]};
        end
        else
        begin
            mapped = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ram_rd_reg    <= 1'b0;
            status_reg    <= '0;
            mapped_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                ram_rd_reg    <= ram_re;
                status_reg    <= st;
                mapped_reg    <= mapped;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A beat is taken only as a waiting result drains, so live state is the state after it
    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign rom_offset        = mapped_reg;
    assign read_data         = ram_rd_reg ? ram_q : 8'd0;
    assign irq_active        = irq_pending;
    assign mirror_horizontal = mirror_h;

    `CBM_ASSERT_IMPLY(a_idle_ready, clk, rst_n, !out_valid, in_ready, "idle output must accept")
    `CBM_ASSERT_IMPLY(a_map_status, clk, rst_n, out_valid && (rom_offset != '0),
        status == cbm_pkg::ST_MAPPED, "offset without mapped status")
    `CBM_ASSERT_IMPLY(a_rd_status, clk, rst_n, out_valid && (read_data != 8'd0),
        status == cbm_pkg::ST_HANDLED, "RAM data without handled status")
    `CBM_ASSERT_NEXT(a_irq_ack, clk, rst_n, accept && (kind == cbm_pkg::KIND_IRQ_ACK),
        !irq_active, "IRQ still active after acknowledge")

endmodule

>>> rtl/core/cbm_wram.sv
// Work RAM: single-port byte store with registered read data.
// No package dependencies.
module cbm_wram #(
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/cbm_regs.sv
// Mapper control registers: bank select, bank data, window bases,
// mirroring and scanline IRQ counter. Depends on cbm_pkg.
module cbm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [5:0]                    cfg_wr_data,
    input  logic                          cmd_valid,
    input  cbm_pkg::reg_cmd_t             cmd,
    input  logic [1:0]                    prg_sel,
    input  logic [2:0]                    chr_sel,
    output logic [cbm_pkg::ADDR_W-1:0]    prg_base,
    output logic [cbm_pkg::ADDR_W-1:0]    chr_base,
    output logic                          irq_pending,
    output logic                          mirror_h
);

    localparam int AW = cbm_pkg::ADDR_W;

    logic [5:0]    bank16_reg;
    logic [2:0]    target_reg;
    logic          prg_swap_reg;
    logic          chr_inv_reg;
    logic          mirror_reg;
    logic [7:0]    bank_reg      [8];
    logic [AW-1:0] chr_base_reg  [8];
    logic [AW-1:0] prg_base_reg  [4];
    logic [7:0]    irq_cnt_reg;
    logic [7:0]    irq_reload_reg;
    logic          irq_en_reg;
    logic          irq_pend_reg;

    logic [7:0]    bank_next     [8];
    logic [AW-1:0] chr_base_next [8];
    logic [AW-1:0] prg_base_next [4];
    logic [7:0]    irq_cnt_dec;
    logic [5:0]    last2;
    logic [5:0]    last1;
    logic [5:0]    last2_rst;
    logic [5:0]    last1_rst;
    logic [2:0]    lo;
    logic [2:0]    hi;

    // Last-bank numbers in 8 KB units, wrapping like the 19-bit offset
    assign last2     = {bank16_reg[4:0] - 5'd1, 1'b0};
    assign last1     = {bank16_reg[4:0] - 5'd1, 1'b1};
    assign last2_rst = {cbm_pkg::BANK16_RST[4:0] - 5'd1, 1'b0};
    assign last1_rst = {cbm_pkg::BANK16_RST[4:0] - 5'd1, 1'b1};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            bank_next[i] = bank_reg[i];
        end
        bank_next[target_reg] = cmd.data;

        lo = chr_inv_reg ? 3'd4 : 3'd0;
        hi = chr_inv_reg ? 3'd0 : 3'd4;
        for (int i = 0; i < 8; i++)
        begin
            chr_base_next[i] = '0;
        end
        chr_base_next[lo]        = AW'({bank_next[0][7:1], 1'b0, 10'b0});
        chr_base_next[lo + 3'd1] = AW'({{1'b0, bank_next[0]} + 9'd1, 10'b0});
        chr_base_next[lo + 3'd2] = AW'({bank_next[1][7:1], 1'b0, 10'b0});
        chr_base_next[lo + 3'd3] = AW'({{1'b0, bank_next[1]} + 9'd1, 10'b0});
        for (int k = 0; k < 4; k++)
        begin
            chr_base_next[hi + 3'(k)] = AW'({bank_next[2 + k], 10'b0});
        end

        if (prg_swap_reg)
        begin
            prg_base_next[2] = {bank_next[6][5:0], 13'b0};
            prg_base_next[0] = {last2, 13'b0};
        end
        else
        begin
            prg_base_next[0] = {bank_next[6][5:0], 13'b0};
            prg_base_next[2] = {last2, 13'b0};
        end
        prg_base_next[1] = {bank_next[7][5:0], 13'b0};
        prg_base_next[3] = {last1, 13'b0};

        irq_cnt_dec = (irq_cnt_reg == 8'd0) ? irq_reload_reg : irq_cnt_reg - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank16_reg     <= cbm_pkg::BANK16_RST;
            target_reg     <= '0;
            prg_swap_reg   <= 1'b0;
            chr_inv_reg    <= 1'b0;
            mirror_reg     <= 1'b1;
            for (int i = 0; i < 8; i++)
            begin
                bank_reg[i]     <= '0;
                chr_base_reg[i] <= '0;
            end
            prg_base_reg[0] <= '0;
            prg_base_reg[1] <= AW'(20'h02000);
            prg_base_reg[2] <= {last2_rst, 13'b0};
            prg_base_reg[3] <= {last1_rst, 13'b0};
            irq_cnt_reg    <= '0;
            irq_reload_reg <= '0;
            irq_en_reg     <= 1'b0;
            irq_pend_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bank16_reg <= cfg_wr_data;
            end
            if (cmd_valid)
            begin
                if (cmd.bank_sel_wr)
                begin
                    target_reg   <= cmd.data[2:0];
                    prg_swap_reg <= cmd.data[6];
                    chr_inv_reg  <= cmd.data[7];
                end
                if (cmd.bank_data_wr)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        bank_reg[i]     <= bank_next[i];
                        chr_base_reg[i] <= chr_base_next[i];
                    end
                    for (int i = 0; i < 4; i++)
                    begin
                        prg_base_reg[i] <= prg_base_next[i];
                    end
                end
                if (cmd.mirror_wr)
                begin
                    mirror_reg <= cmd.data[0];
                end
                if (cmd.irq_reload_wr)
                begin
                    irq_reload_reg <= cmd.data;
                end
                if (cmd.irq_cnt_clr)
                begin
                    irq_cnt_reg <= '0;
                end
                if (cmd.irq_disable)
                begin
                    irq_en_reg   <= 1'b0;
                    irq_pend_reg <= 1'b0;
                end
                if (cmd.irq_enable)
                begin
                    irq_en_reg <= 1'b1;
                end
                if (cmd.scanline)
                begin
                    irq_cnt_reg <= irq_cnt_dec;
                    if (irq_cnt_dec == 8'd0 && irq_en_reg)
                    begin
                        irq_pend_reg <= 1'b1;
                    end
                end
                if (cmd.irq_ack)
                begin
                    irq_pend_reg <= 1'b0;
                end
            end
        end
    end

    assign prg_base    = prg_base_reg[prg_sel];
    assign chr_base    = chr_base_reg[chr_sel];
    assign irq_pending = irq_pend_reg;
    assign mirror_h    = mirror_reg;

endmodule
